// ===== rtl/core/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = 7;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int PRIO_W   = 32;
	localparam int PAY_W    = 32;

	typedef enum logic [0:0] {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [PRIO_W-1:0] priority_req;
		logic [PAY_W-1:0]         payload;
	} hpq_req_t;

	typedef struct packed {
		status_t                  status;
		logic [CNT_W-1:0]         count;
		logic                     top_valid;
		logic signed [PRIO_W-1:0] top_priority;
		logic [PAY_W-1:0]         top_payload;
	} hpq_rsp_t;

endpackage

// ===== rtl/core/hpq_mem.sv =====
// ----------------------------------------------------------------------------
// hpq_mem
// Heap entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hpq_mem #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/hpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sift sequencer: walks the heap one level at a time through the entry
// store, using a single signed priority comparator for every decision.
// ----------------------------------------------------------------------------
module hpq_ctrl
	import hpq_pkg::*;
#(
	parameter int PAYLOAD_BITS = 32,
	localparam int EW = PRIO_W + PAYLOAD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  hpq_req_t          req,
	output logic              res_valid,
	input  logic              res_ready,
	output hpq_rsp_t          res,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic [EW-1:0]     mem_wdata,
	output logic [ADDR_W-1:0] mem_raddr,
	input  logic [EW-1:0]     mem_rdata
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_UP_RD   = 9'b000000010,
		S_UP_CMP  = 9'b000000100,
		S_DN_LOAD = 9'b000001000,
		S_DN_RL   = 9'b000010000,
		S_DN_RR   = 9'b000100000,
		S_DN_CMP  = 9'b001000000,
		S_OUT     = 9'b010000000,
		S_SPARE   = 9'b100000000
	} state_t;

	localparam int CW2 = ADDR_W + 2;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] par_q;
	logic [EW-1:0]     e_q;
	logic [EW-1:0]     best_q;
	logic [EW-1:0]     root_q;
	logic              pickl_q;
	logic              rok_q;
	status_t           status_q;

	logic [EW-1:0]     cmp_a, cmp_b;
	logic              cmp_lt;
	logic [ADDR_W-1:0] parent;
	logic [CW2-1:0]    l_w, r_w, cnt_w;
	logic              l_in, r_in;
	logic              pickr;
	logic              is_full;

	assign parent  = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
	assign l_w     = {1'b0, pos_q, 1'b1};
	assign r_w     = {1'b0, pos_q, 1'b0} + CW2'(2);
	assign cnt_w   = CW2'(cnt_q);
	assign l_in    = l_w < cnt_w;
	assign r_in    = r_w < cnt_w;
	assign pickr   = rok_q && cmp_lt;
	assign is_full = cnt_q == CNT_W'(CAPACITY);

	// shared comparator
	always_comb begin
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = e_q;
				cmp_b = mem_rdata;
			end
			S_DN_RR: begin
				cmp_a = mem_rdata;
				cmp_b = e_q;
			end
			default: begin
				cmp_a = mem_rdata;
				cmp_b = best_q;
			end
		endcase
	end

	assign cmp_lt = $signed(cmp_a[EW-1 -: PRIO_W]) < $signed(cmp_b[EW-1 -: PRIO_W]);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = e_q;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.cmd == CMD_PUSH) begin
						state_d = is_full ? S_OUT : S_UP_RD;
					end else if (cnt_q <= CNT_W'(1)) begin
						state_d = S_OUT;
					end else begin
						mem_raddr = ADDR_W'(cnt_q - CNT_W'(1));
						state_d   = S_DN_LOAD;
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_OUT;
				end else begin
					mem_raddr = parent;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp_lt) begin
					mem_wdata = mem_rdata;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DN_LOAD: begin
				state_d = S_DN_RL;
			end
			S_DN_RL: begin
				if (l_in) begin
					mem_raddr = l_w[ADDR_W-1:0];
					state_d   = S_DN_RR;
				end else begin
					mem_we  = 1'b1;
					state_d = S_OUT;
				end
			end
			S_DN_RR: begin
				mem_raddr = r_w[ADDR_W-1:0];
				state_d   = S_DN_CMP;
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (pickr) begin
					mem_wdata = mem_rdata;
					state_d   = S_DN_RL;
				end else if (pickl_q) begin
					mem_wdata = best_q;
					state_d   = S_DN_RL;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid) begin
				if (req.cmd == CMD_PUSH) begin
					if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
						cnt_q    <= cnt_q + CNT_W'(1);
					end
				end else if (cnt_q == '0) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_OK;
					cnt_q    <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req.cmd == CMD_PUSH) begin
					e_q   <= {req.priority_req, req.payload[PAYLOAD_BITS-1:0]};
					pos_q <= ADDR_W'(cnt_q);
				end else begin
					pos_q <= '0;
				end
			end
			S_UP_RD: begin
				par_q <= parent;
			end
			S_UP_CMP: begin
				if (cmp_lt) begin
					pos_q <= par_q;
				end
			end
			S_DN_LOAD: begin
				e_q <= mem_rdata;
			end
			S_DN_RR: begin
				pickl_q <= cmp_lt;
				best_q  <= cmp_lt ? mem_rdata : e_q;
				rok_q   <= r_in;
			end
			S_DN_CMP: begin
				if (pickr) begin
					pos_q <= r_w[ADDR_W-1:0];
				end else if (pickl_q) begin
					pos_q <= l_w[ADDR_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;

	always_comb begin
		res.status       = status_q;
		res.count        = cnt_q;
		res.top_valid    = cnt_q != '0;
		res.top_priority = '0;
		res.top_payload  = '0;
		if (cnt_q != '0) begin
			res.top_priority = root_q[EW-1 -: PRIO_W];
			res.top_payload  = PAY_W'(root_q[PAYLOAD_BITS-1:0]);
		end
	end

endmodule

// ===== rtl/core/binary_min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue
// Fixed-capacity binary min-heap with push/pop requests and one response each.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): one item per operation, push of
//   (priority_req, payload) or pop of the root. req_ready is high only while
//   the sequencer is idle.
//   rsp channel (rsp_valid/rsp_ready/rsp): one item per request with status,
//   count and the root entry after the operation.
//   From accept to rsp_valid: a push reads its parent and compares once per
//   level the new entry climbs (S_UP_RD, S_UP_CMP); a pop loads the last
//   entry, then reads the left and right child and compares once per level
//   it sinks (S_DN_RL, S_DN_RR, S_DN_CMP); rejected push, empty pop and pop
//   of the last entry go straight to the response state (S_OUT).
//   The pace is set by the entry store's one read port with registered
//   data: parent and child reads go through it one at a time.
//   A new request is taken only once the previous response has left the
//   sequencer; it is taken while that response still waits in the output
//   register.
//   Reset empties the queue (count to zero); store contents are not cleared.
//   If rsp_ready stays low, one response is held and the sequencer then
//   waits with its next response, holding req_ready low.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue
	import hpq_pkg::*;
#(
	parameter int PAYLOAD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  hpq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output hpq_rsp_t rsp
);

	localparam int EW = PRIO_W + PAYLOAD_BITS;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [EW-1:0]     mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [EW-1:0]     mem_rdata;
	logic              res_valid;
	logic              res_ready;
	hpq_rsp_t          res;
	logic              rsp_valid_q;
	hpq_rsp_t          rsp_q;

	hpq_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	hpq_ctrl #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/hpq_chk.sv =====
// ----------------------------------------------------------------------------
// hpq_chk
// Port-level checks for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module hpq_chk
	import hpq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input hpq_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.top_valid == (rsp.count != '0))
		else $error("top_valid disagrees with count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count == CNT_W'(CAPACITY))
		else $error("full status with queue not full");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0)
		else $error("empty status with entries present");

	a_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.top_valid |-> rsp.top_priority == '0 && rsp.top_payload == '0)
		else $error("top fields not zero on empty queue");

endmodule

bind binary_min_heap_priority_queue hpq_chk u_hpq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_min_heap_priority_queue.
// A shadow heap tracks every accepted item. Each response is checked field by
// field against the oldest pending prediction. Directed corner items run
// first. Random fill/drain runs with tied and extreme priorities follow,
// under three request/response stall mixes.
// ----------------------------------------------------------------------------
module tb;
	import hpq_pkg::*;

	localparam int PAYLOAD_BITS = 32;
	localparam logic [PAY_W-1:0] PAY_MASK = PAY_W'((64'd1 << PAYLOAD_BITS) - 64'd1);
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 400;

	class heap_shadow;
		logic signed [PRIO_W-1:0] prio_a [CAPACITY];
		logic [PAY_W-1:0]         pay_a [CAPACITY];
		int                       depth;
		hpq_rsp_t                 rsp_due [$];
		int errors, n_push, n_pop, n_full, n_empty, n_checked, peak;

		function new();
			depth     = 0;
			errors    = 0;
			n_push    = 0;
			n_pop     = 0;
			n_full    = 0;
			n_empty   = 0;
			n_checked = 0;
			peak      = 0;
		endfunction

		function void note_request(hpq_req_t r);
			hpq_rsp_t                 e;
			int                       pos, parent, pick, kid;
			logic signed [PRIO_W-1:0] tp;
			logic [PAY_W-1:0]         td;
			e.status = ST_OK;
			if (r.cmd == CMD_PUSH) begin
				n_push++;
				if (depth >= CAPACITY) begin
					e.status = ST_FULL;
					n_full++;
				end else begin
					pos = depth;
					depth++;
					while (pos > 0) begin
						parent = (pos - 1) / 2;
						if (!($signed(r.priority_req) < $signed(prio_a[parent])))
							break;
						prio_a[pos] = prio_a[parent];
						pay_a[pos]  = pay_a[parent];
						pos = parent;
					end
					prio_a[pos] = r.priority_req;
					pay_a[pos]  = r.payload & PAY_MASK;
				end
			end else begin
				n_pop++;
				if (depth == 0) begin
					e.status = ST_EMPTY;
					n_empty++;
				end else if (depth == 1) begin
					depth = 0;
				end else begin
					prio_a[0] = prio_a[depth-1];
					pay_a[0]  = pay_a[depth-1];
					depth--;
					pos = 0;
					forever begin
						pick = pos;
						kid  = 2 * pos + 1;
						if (kid < depth && $signed(prio_a[kid]) < $signed(prio_a[pick]))
							pick = kid;
						kid++;
						if (kid < depth && $signed(prio_a[kid]) < $signed(prio_a[pick]))
							pick = kid;
						if (pick == pos)
							break;
						tp = prio_a[pos];
						td = pay_a[pos];
						prio_a[pos]  = prio_a[pick];
						pay_a[pos]   = pay_a[pick];
						prio_a[pick] = tp;
						pay_a[pick]  = td;
						pos = pick;
					end
				end
			end
			if (depth > peak)
				peak = depth;
			e.count        = CNT_W'(depth);
			e.top_valid    = (depth > 0);
			e.top_priority = (depth > 0) ? prio_a[0] : '0;
			e.top_payload  = (depth > 0) ? pay_a[0] : '0;
			rsp_due.push_back(e);
		endfunction

		function void check_response(hpq_rsp_t got);
			hpq_rsp_t e;
			if (rsp_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: response with nothing pending: status=%0d count=%0d",
						$time, got.status, got.count);
				return;
			end
			e = rsp_due.pop_front();
			n_checked++;
			if (got.status !== e.status || got.count !== e.count ||
				got.top_valid !== e.top_valid || got.top_priority !== e.top_priority ||
				got.top_payload !== e.top_payload) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch on response %0d", $time, n_checked);
					$display("  exp status=%0d count=%0d valid=%0b prio=%0d pay=%h",
						e.status, e.count, e.top_valid, e.top_priority, e.top_payload);
					$display("  got status=%0d count=%0d valid=%0b prio=%0d pay=%h",
						got.status, got.count, got.top_valid, got.top_priority,
						got.top_payload);
				end
			end
		endfunction

		function int pending();
			return rsp_due.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	hpq_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	hpq_rsp_t rsp;

	heap_shadow sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	int gen_count;
	int cycle_cnt;

	binary_min_heap_priority_queue #(
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("binary_min_heap_priority_queue regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			sb.note_request(req);
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
	end

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic send_item(input hpq_req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic push_item(input logic signed [PRIO_W-1:0] p, input logic [PAY_W-1:0] d);
		hpq_req_t r;
		r.cmd          = CMD_PUSH;
		r.priority_req = p;
		r.payload      = d;
		if (gen_count < CAPACITY)
			gen_count++;
		send_item(r);
	endtask

	task automatic pop_item();
		hpq_req_t r;
		r.cmd          = CMD_POP;
		r.priority_req = $urandom;
		r.payload      = $urandom;
		if (gen_count > 0)
			gen_count--;
		send_item(r);
	endtask

	// fill runs until full (plus some refused pushes), then drain runs to empty
	task automatic run_random(input int n);
		logic                     filling;
		int                       sel;
		logic signed [PRIO_W-1:0] p;
		filling = 1'b1;
		repeat (n) begin
			if (filling && gen_count == CAPACITY && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && gen_count == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
			if ($urandom_range(0, 99) < (filling ? 85 : 15)) begin
				sel = $urandom_range(0, 9);
				if (sel < 4)
					p = $signed(32'($urandom_range(0, 15))) - 32'sd8;
				else if (sel == 4)
					case ($urandom_range(0, 3))
						0: p = 32'sh7fffffff;
						1: p = 32'sh80000000;
						2: p = 32'sd0;
						default: p = -32'sd1;
					endcase
				else
					p = $urandom;
				push_item(p, $urandom);
			end else begin
				pop_item();
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_ready     = 1'b0;
		cycle_cnt     = 0;
		gen_count     = 0;
		send_idle_pct = 33;
		recv_idle_pct = 73;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pop, single-entry pop, extremes, ties (strict sift, left on equal)
		pop_item();
		push_item(32'sd0, 32'h0000_0000);
		pop_item();
		pop_item();
		push_item(32'sh7fffffff, 32'hffff_ffff);
		push_item(32'sh80000000, 32'haaaa_aaaa);
		push_item(-32'sd1, 32'h5555_5555);
		push_item(32'sd0, 32'hffff_ffff);
		push_item(32'sh80000000, 32'h1234_5678);
		push_item(-32'sd1, 32'h8765_4321);
		pop_item();
		pop_item();
		pop_item();
		push_item(32'sd5, 32'h0000_0001);
		push_item(32'sd5, 32'h0000_0002);
		push_item(32'sd5, 32'h0000_0003);
		push_item(32'sd5, 32'h0000_0004);
		pop_item();
		pop_item();
		pop_item();
		pop_item();
		pop_item();
		pop_item();
		pop_item();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 73 : 0;
			recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 33 : 0;
			run_random((ph == 2) ? RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) : RANDOM_ITEMS / 3);
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d pushes (%0d refused when full), %0d pops (%0d on empty)",
			sb.n_push, sb.n_full, sb.n_pop, sb.n_empty);
		$display("peak depth %0d of %0d, %0d responses checked, %0d mismatches",
			sb.peak, CAPACITY, sb.n_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("binary_min_heap_priority_queue regression: pass");
		end else begin
			$display("binary_min_heap_priority_queue regression: fail");
		end
		$finish;
	end

endmodule
